// ----- design/bkh_pkg.sv -----
`timescale 1ns / 1ps

package bkh_pkg;

    localparam int unsigned CHUNK_W = 64;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned HASH_W  = 32;
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned HALF_W  = 32;

    localparam logic [CHUNK_W-1:0] SEED_VALUE = 64'd2166136261;
    localparam logic [CHUNK_W-1:0] BLOCK_MUL  = 64'hbf58476d1ce4e5b9;
    localparam logic [CHUNK_W-1:0] TAIL_MUL   = 64'hd6e8feb86659fd93;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;
    localparam logic [LEN_W-1:0]   FULL_STEP  = 8'd8;

    typedef logic [CHUNK_W-1:0] word_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [HASH_W-1:0]  hash_t;
    typedef logic [COUNT_W-1:0] count_t;

endpackage

// ----- design/bkh_ifs.sv -----
`timescale 1ns / 1ps

interface bkh_in_if;
    logic              valid;
    logic              ready;
    bkh_pkg::word_t    chunk_bytes;
    bkh_pkg::count_t   valid_bytes;
    logic              last_chunk;

    modport source (output valid, output chunk_bytes, output valid_bytes,
                    output last_chunk, input ready);
    modport sink   (input valid, input chunk_bytes, input valid_bytes,
                    input last_chunk, output ready);
endinterface

interface bkh_out_if;
    logic              valid;
    logic              ready;
    bkh_pkg::hash_t    key_hash;

    modport source (output valid, output key_hash, input ready);
    modport sink   (input valid, input key_hash, output ready);
endinterface

// ----- design/byte_key_hash_64_to_32_core.sv -----
`timescale 1ns / 1ps

// Byte-key hash core. A key streams in on 'key' as 8-byte little-endian
// chunks, one transaction per chunk, at up to one chunk per clock cycle; the
// 32-bit hash of each key leaves on 'hash' as one transaction. A chunk is
// held in the input register and from there mixed into the 64-bit
// accumulator; the hash of a key goes into the output register when its last
// chunk leaves the input register. The cycle time is set by the
// accumulator loop: XOR and a 64-bit low-half multiply built from three
// 32x32 partial products, between the input register and the accumulator,
// with the fold to 32 bits behind the multiply on the way to the output
// register. Non-last chunks always count as 8 bytes; on the last chunk
// valid_bytes of 9..15 means 8, and 0 emits the hash of what was mixed so
// far. After each hash the accumulator returns to its seed. Back-pressure on
// 'hash' only stalls the pipe when a last chunk wants the occupied output
// register.
module byte_key_hash_64_to_32_core (
    input  logic       clk,
    input  logic       rst_n,
    bkh_in_if.sink     key,
    bkh_out_if.source  hash
);

    // input register
    logic            s1_valid_reg;
    logic            s1_valid_next;
    bkh_pkg::word_t  s1_chunk_reg;
    bkh_pkg::count_t s1_count_reg;
    logic            s1_last_reg;

    // running state
    bkh_pkg::word_t  acc_reg;
    bkh_pkg::len_t   len_reg;
    bkh_pkg::word_t  acc_mix;
    bkh_pkg::len_t   len_mix;
    bkh_pkg::hash_t  hash_mix;

    // output register
    logic            out_valid_reg;
    logic            out_valid_next;
    bkh_pkg::hash_t  hash_reg;

    logic            out_free;
    logic            s1_fire;
    logic            key_fire;

    assign out_free = !out_valid_reg || hash.ready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign key.ready = !s1_valid_reg || s1_fire;
    assign key_fire = key.valid && key.ready;

    assign s1_valid_next = key_fire || (s1_valid_reg && !s1_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_fire)
        begin
            s1_chunk_reg <= key.chunk_bytes;
            s1_count_reg <= key.valid_bytes;
            s1_last_reg  <= key.last_chunk;
        end
    end

    bkh_mix u_mix (
        .acc         (acc_reg),
        .len         (len_reg),
        .chunk_bytes (s1_chunk_reg),
        .valid_bytes (s1_count_reg),
        .last_chunk  (s1_last_reg),
        .acc_next    (acc_mix),
        .len_next    (len_mix),
        .key_hash    (hash_mix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= bkh_pkg::SEED_VALUE;
            len_reg <= '0;
        end
        else if (s1_fire)
        begin
            acc_reg <= acc_mix;
            len_reg <= len_mix;
        end
    end

    // output register: loaded by a last chunk, emptied by a hash transaction
    assign out_valid_next = (s1_fire && s1_last_reg) || (out_valid_reg && !hash.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            hash_reg <= hash_mix;
        end
    end

    assign hash.valid    = out_valid_reg;
    assign hash.key_hash = hash_reg;

`ifndef SYNTHESIS
    // a finished key leaves the state at its seed
    a_reseed: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> acc_reg == bkh_pkg::SEED_VALUE && len_reg == '0)
        else $error("state not reseeded after last chunk");

    // a last chunk blocked by a full output register stays put
    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg && out_valid_reg && !hash.ready
        |=> s1_valid_reg && s1_last_reg && $stable(s1_chunk_reg))
        else $error("stalled last chunk lost");

    // an empty input register always takes a chunk
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> key.ready)
        else $error("input refused with empty stage");

    // a hash appears only after a last chunk was mixed
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && s1_last_reg))
        else $error("hash without last chunk");

    // non-last chunks never stall on the output side
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_last_reg |-> s1_fire)
        else $error("non-last chunk stalled");
`endif

endmodule

// ----- design/bkh_mul64lo.sv -----
`timescale 1ns / 1ps

// Low 64 bits of a 64x64 product from three 32x32 partial products.
// The high x high term only lands above bit 63 and is dropped.
module bkh_mul64lo (
    input  bkh_pkg::word_t a,
    input  bkh_pkg::word_t b,
    output bkh_pkg::word_t p
);

    logic [2*bkh_pkg::HALF_W-1:0] lo_lo;
    logic [bkh_pkg::HALF_W-1:0]   lo_hi;
    logic [bkh_pkg::HALF_W-1:0]   hi_lo;
    logic [bkh_pkg::HALF_W-1:0]   mid_sum;

    assign lo_lo = a[bkh_pkg::HALF_W-1:0] * b[bkh_pkg::HALF_W-1:0];
    assign lo_hi = bkh_pkg::HALF_W'(a[bkh_pkg::HALF_W-1:0]
                                    * b[bkh_pkg::CHUNK_W-1:bkh_pkg::HALF_W]);
    assign hi_lo = bkh_pkg::HALF_W'(a[bkh_pkg::CHUNK_W-1:bkh_pkg::HALF_W]
                                    * b[bkh_pkg::HALF_W-1:0]);
    assign mid_sum = lo_hi + hi_lo;
    assign p       = lo_lo + {mid_sum, {bkh_pkg::HALF_W{1'b0}}};

endmodule

// ----- design/bkh_mix.sv -----
`timescale 1ns / 1ps

// One chunk folded into the running state: full-chunk mix, tail mix or none.
module bkh_mix (
    input  bkh_pkg::word_t  acc,
    input  bkh_pkg::len_t   len,
    input  bkh_pkg::word_t  chunk_bytes,
    input  bkh_pkg::count_t valid_bytes,
    input  logic            last_chunk,
    output bkh_pkg::word_t  acc_next,
    output bkh_pkg::len_t   len_next,
    output bkh_pkg::hash_t  key_hash
);

    bkh_pkg::count_t cnt;
    logic            full;
    logic            tail;
    bkh_pkg::len_t   len_mix;
    bkh_pkg::word_t  keep;
    bkh_pkg::word_t  masked;
    bkh_pkg::word_t  tail_word;
    bkh_pkg::word_t  word;
    bkh_pkg::word_t  mult;
    bkh_pkg::word_t  acc_mixed;
    bkh_pkg::word_t  acc_after;

    // saturate oversized counts on the final chunk
    assign cnt  = (valid_bytes > bkh_pkg::FULL_COUNT) ? bkh_pkg::FULL_COUNT : valid_bytes;
    assign full = !last_chunk || (cnt == bkh_pkg::FULL_COUNT);
    assign tail = last_chunk && (cnt != '0) && (cnt != bkh_pkg::FULL_COUNT);

    assign len_mix = len + (full ? bkh_pkg::FULL_STEP
                                 : {{(bkh_pkg::LEN_W-bkh_pkg::COUNT_W){1'b0}}, cnt});

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            keep[b*8 +: 8] = (bkh_pkg::COUNT_W'(b) < cnt) ? 8'hff : 8'h00;
        end
    end

    // tail word: length in the low byte, kept tail bytes above it
    assign masked    = chunk_bytes & keep;
    assign tail_word = {masked[bkh_pkg::CHUNK_W-bkh_pkg::LEN_W-1:0], len_mix};

    assign word = full ? chunk_bytes : tail_word;
    assign mult = full ? bkh_pkg::BLOCK_MUL : bkh_pkg::TAIL_MUL;

    bkh_mul64lo u_mul (
        .a (acc ^ word),
        .b (mult),
        .p (acc_mixed)
    );

    assign acc_after = (full || tail) ? acc_mixed : acc;
    assign key_hash  = acc_after[bkh_pkg::HASH_W-1:0]
                     ^ acc_after[bkh_pkg::CHUNK_W-1:bkh_pkg::HASH_W];

    assign acc_next = last_chunk ? bkh_pkg::SEED_VALUE : acc_after;
    assign len_next = last_chunk ? '0 : len_mix;

endmodule

// ----- tb/key_hash_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, predicts the hash of every key from the chunks seen
// on 'key' and compares each hash transaction against the oldest prediction.
module key_hash_checker (
    input  logic clk,
    input  logic rst_n,
    bkh_in_if    key,
    bkh_out_if   hash,
    output int   fail_count,
    output int   pending
);

    bkh_pkg::word_t acc_state;
    bkh_pkg::len_t  len_seen;
    bkh_pkg::hash_t expected_hashes[$];
    int             errors;

    task automatic report_mismatch(input string msg);
        $display("[%0t] hash mismatch: %s", $time, msg);
        errors++;
    endtask

    // Mixes one chunk into the predicted state; on a last chunk the folded
    // hash is queued and the state goes back to the seed.
    task automatic absorb_chunk(input bkh_pkg::word_t chunk,
                                input bkh_pkg::count_t nbytes,
                                input logic last);
        bkh_pkg::count_t cnt;
        bkh_pkg::word_t  keep;
        bkh_pkg::word_t  tail_word;
        if (!last || nbytes >= bkh_pkg::FULL_COUNT)
        begin
            acc_state = (acc_state ^ chunk) * bkh_pkg::BLOCK_MUL;
            len_seen  = len_seen + bkh_pkg::FULL_STEP;
        end
        else if (nbytes != '0)
        begin
            cnt       = nbytes;
            keep      = (bkh_pkg::word_t'(1) << (8 * cnt)) - bkh_pkg::word_t'(1);
            len_seen  = len_seen + bkh_pkg::len_t'(cnt);
            tail_word = bkh_pkg::word_t'(len_seen) | ((chunk & keep) << 8);
            acc_state = (acc_state ^ tail_word) * bkh_pkg::TAIL_MUL;
        end
        if (last)
        begin
            expected_hashes.push_back(acc_state[bkh_pkg::HALF_W-1:0]
                                      ^ acc_state[bkh_pkg::CHUNK_W-1:bkh_pkg::HALF_W]);
            acc_state = bkh_pkg::SEED_VALUE;
            len_seen  = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_state = bkh_pkg::SEED_VALUE;
            len_seen  = '0;
            expected_hashes.delete();
            errors    = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // retire the output first so a same-edge chunk cannot mask a stray hash
            if (hash.valid && hash.ready)
            begin
                if (expected_hashes.size() == 0)
                    report_mismatch($sformatf("unexpected key_hash %08h", hash.key_hash));
                else
                begin
                    if (hash.key_hash !== expected_hashes[0])
                        report_mismatch($sformatf("key_hash got %08h want %08h",
                                                  hash.key_hash, expected_hashes[0]));
                    void'(expected_hashes.pop_front());
                end
            end
            if (key.valid && key.ready)
                absorb_chunk(key.chunk_bytes, key.valid_bytes, key.last_chunk);
            fail_count <= errors;
            pending    <= expected_hashes.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Top of the hash testbench: clock, reset, chunk stimulus on 'key', random
// back-pressure on 'hash', and the final verdict. All checking lives in
// key_hash_checker.
module tb_top;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   chunks_sent;
    bit   in_burst;     // no gaps between chunk transactions while set
    bit   out_burst;    // hash sink always ready while set

    bkh_in_if  key_ch ();
    bkh_out_if hash_ch ();

    byte_key_hash_64_to_32_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (key_ch),
        .hash  (hash_ch)
    );

    key_hash_checker hash_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key_ch),
        .hash       (hash_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run: ~900 chunks, each with its
    // longest idle gap plus its longest output stall, is far under 1 ms.
    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Random chunk payload, with the all-zero and all-one words mixed in
    // so the extremes show up in every key position.
    function automatic bkh_pkg::word_t pick_chunk();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One chunk transaction. The gap is drawn per chunk; valid only drops
    // when there is a gap, so back-to-back chunks keep valid high. Ready is
    // looked at on the falling edge, where it has settled for the next
    // rising edge, which is then the accepting edge.
    task automatic send_chunk(input bkh_pkg::word_t chunk,
                              input bkh_pkg::count_t nbytes,
                              input logic last);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            key_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_ch.valid       <= 1'b1;
        key_ch.chunk_bytes <= chunk;
        key_ch.valid_bytes <= nbytes;
        key_ch.last_chunk  <= last;
        do @(negedge clk); while (!key_ch.ready);
        @(posedge clk);
        chunks_sent++;
    endtask

    // Hash sink: per transaction a stall of random length, except in bursts
    // where ready stays up.
    initial
    begin
        int stall;
        hash_ch.ready <= 1'b0;
        out_burst = 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
                out_burst = ~out_burst;
            stall = out_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                hash_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            hash_ch.ready <= 1'b1;
            do @(negedge clk); while (!hash_ch.valid);
            @(posedge clk);
        end
    end

    initial
    begin
        int nbody;
        int tail_bytes;
        chunks_sent = 0;
        in_burst    = 1'b0;
        rst_n              <= 1'b0;
        key_ch.valid       <= 1'b0;
        key_ch.chunk_bytes <= '0;
        key_ch.valid_bytes <= '0;
        key_ch.last_chunk  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed keys ----
        send_chunk('0, 4'd0, 1'b1);                 // empty key: seed fold only
        send_chunk('1, 4'd1, 1'b1);                 // one byte, upper bytes must be dropped
        send_chunk('1, 4'd7, 1'b1);                 // longest tail
        send_chunk('0, bkh_pkg::FULL_COUNT, 1'b1);  // exact 8 bytes, no tail mix
        send_chunk('1, 4'd15, 1'b1);                // oversized count saturates to 8
        send_chunk(pick_chunk(), 4'd9, 1'b1);
        send_chunk('1, 4'd0, 1'b0);                 // body chunk: count ignored
        send_chunk(pick_chunk(), 4'd3, 1'b1);
        send_chunk('0, 4'd15, 1'b0);
        send_chunk('1, 4'd0, 1'b1);                 // zero-byte last after a body chunk
        for (int n = 2; n <= 6; n++)
            send_chunk(pick_chunk(), bkh_pkg::count_t'(n), 1'b1);
        send_chunk(pick_chunk(), 4'd8, 1'b0);
        send_chunk(pick_chunk(), 4'd12, 1'b1);

        // ---- random keys ----
        // Mostly short keys; now and then a long one that can run the 8-bit
        // length count past 255 before its tail.
        while (chunks_sent < 800)
        begin
            in_burst = ($urandom_range(0, 3) == 0);
            nbody = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40)
                                                 : $urandom_range(0, 4);
            repeat (nbody)
                send_chunk(pick_chunk(), bkh_pkg::count_t'($urandom_range(0, 15)), 1'b0);
            tail_bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 15)
                                                     : $urandom_range(0, 8);
            send_chunk(pick_chunk(), bkh_pkg::count_t'(tail_bytes), 1'b1);
        end
        key_ch.valid <= 1'b0;

        // pending is a registered copy of the checker's queue size
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
